/* hdl/sars_pkg.sv */
// ----------------------------------------------------------------------------
// sars_pkg
// Shared types, register map and link codes for the SPI accelerometer
// register slave.
// ----------------------------------------------------------------------------
package sars_pkg;

  localparam int BYTE_W  = 8;
  localparam int AXIS_W  = 16;
  localparam int ADDR_W  = 8;
  localparam int CMDA_W  = 6;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_AXES = 3;

  // Link mode codes
  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_READ    = 2'd1,
    MODE_BURST   = 2'd2,
    MODE_WRITE   = 2'd3
  } link_mode_t;

  // Operation field of a command byte (top two bits)
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_MULTI = 2'd1,
    OP_READ  = 2'd2,
    OP_BURST = 2'd3
  } cmd_op_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_BASE = 2'd2;

  localparam logic [AXIS_W-1:0] X_BASE_RST = 16'd200;
  localparam logic [AXIS_W-1:0] Y_BASE_RST = 16'd400;
  localparam logic [AXIS_W-1:0] Z_BASE_RST = 16'd800;

  // Register map
  localparam logic [ADDR_W-1:0] A_DEVID0  = 8'h00;
  localparam logic [ADDR_W-1:0] A_DEVID1  = 8'h01;
  localparam logic [ADDR_W-1:0] A_PARTID  = 8'h02;
  localparam logic [ADDR_W-1:0] A_OFS_X   = 8'h1e;
  localparam logic [ADDR_W-1:0] A_OFS_Y   = 8'h1f;
  localparam logic [ADDR_W-1:0] A_OFS_Z   = 8'h20;
  localparam logic [ADDR_W-1:0] A_RATE    = 8'h2c;
  localparam logic [ADDR_W-1:0] A_PWR     = 8'h2d;
  localparam logic [ADDR_W-1:0] A_FMT     = 8'h31;
  localparam logic [ADDR_W-1:0] A_X_LO    = 8'h32;
  localparam logic [ADDR_W-1:0] A_X_HI    = 8'h33;
  localparam logic [ADDR_W-1:0] A_Y_LO    = 8'h34;
  localparam logic [ADDR_W-1:0] A_Y_HI    = 8'h35;
  localparam logic [ADDR_W-1:0] A_Z_LO    = 8'h36;
  localparam logic [ADDR_W-1:0] A_Z_HI    = 8'h37;

  localparam logic [BYTE_W-1:0] V_DEVID0 = 8'had;
  localparam logic [BYTE_W-1:0] V_DEVID1 = 8'h1d;
  localparam logic [BYTE_W-1:0] V_PARTID = 8'hcb;
  localparam logic [BYTE_W-1:0] V_PWR    = 8'h4b;
  localparam logic [BYTE_W-1:0] V_FMT    = 8'h0b;

  typedef struct packed {
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
    logic [AXIS_W-1:0] z;
  } accel_base_t;

  function automatic link_mode_t cmd_to_mode(input logic [BYTE_W-1:0] cmd);
    link_mode_t m;
    case (cmd_op_t'(cmd[BYTE_W-1:CMDA_W]))
      OP_WRITE: m = MODE_WRITE;
      OP_MULTI: m = MODE_STANDBY;
      OP_READ:  m = MODE_READ;
      OP_BURST: m = MODE_BURST;
      default:  m = MODE_STANDBY;
    endcase
    return m;
  endfunction

endpackage

/* hdl/sars_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sars_cfg_regs
// Holds the per-axis base values written over the config port.
// ----------------------------------------------------------------------------
module sars_cfg_regs
  import sars_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_idx,
  input  logic [AXIS_W-1:0]    wr_data,
  output accel_base_t          base
);

  accel_base_t base_r, base_nxt;

  always_comb begin
    base_nxt = base_r;
    if (wr_en) begin
      case (wr_idx)
        CFG_X_BASE: base_nxt.x = wr_data;
        CFG_Y_BASE: base_nxt.y = wr_data;
        CFG_Z_BASE: base_nxt.z = wr_data;
        default:    base_nxt   = base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r.x <= X_BASE_RST;
      base_r.y <= Y_BASE_RST;
      base_r.z <= Z_BASE_RST;
    end else begin
      base_r <= base_nxt;
    end
  end

  assign base = base_r;

endmodule

/* hdl/sars_core.sv */
// ----------------------------------------------------------------------------
// sars_core
// Link state, device registers and read mux. One byte is processed per
// cycle when step_en is high.
// ----------------------------------------------------------------------------
module sars_core
  import sars_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [BYTE_W-1:0] step_byte,
  input  accel_base_t       base,
  output logic [BYTE_W-1:0] resp
);

  link_mode_t        mode_r, mode_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [BYTE_W-1:0] rate_r, rate_nxt;
  logic [BYTE_W-1:0] ofs_r   [NUM_AXES];
  logic [BYTE_W-1:0] ofs_nxt [NUM_AXES];

  logic [AXIS_W:0]   sum_x, sum_y, sum_z;
  logic [BYTE_W-1:0] rd_data;
  logic              is_cmd;
  logic              do_read;
  logic              do_write;

  assign sum_x = {1'b0, base.x} + {{(AXIS_W-BYTE_W+1){1'b0}}, ofs_r[0]};
  assign sum_y = {1'b0, base.y} + {{(AXIS_W-BYTE_W+1){1'b0}}, ofs_r[1]};
  assign sum_z = {1'b0, base.z} + {{(AXIS_W-BYTE_W+1){1'b0}}, ofs_r[2]};

  always_comb begin
    case (addr_r)
      A_DEVID0: rd_data = V_DEVID0;
      A_DEVID1: rd_data = V_DEVID1;
      A_PARTID: rd_data = V_PARTID;
      A_PWR:    rd_data = V_PWR;
      A_FMT:    rd_data = V_FMT;
      A_RATE:   rd_data = rate_r;
      A_OFS_X:  rd_data = ofs_r[0];
      A_OFS_Y:  rd_data = ofs_r[1];
      A_OFS_Z:  rd_data = ofs_r[2];
      A_X_LO:   rd_data = sum_x[BYTE_W-1:0];
      A_X_HI:   rd_data = sum_x[AXIS_W-1:BYTE_W];
      A_Y_LO:   rd_data = sum_y[BYTE_W-1:0];
      A_Y_HI:   rd_data = sum_y[AXIS_W-1:BYTE_W];
      A_Z_LO:   rd_data = sum_z[BYTE_W-1:0];
      A_Z_HI:   rd_data = sum_z[AXIS_W-1:BYTE_W];
      default:  rd_data = '0;
    endcase
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    if (step_en) begin
      case (mode_r)
        MODE_BURST: begin
          if (step_byte != '0) mode_nxt = cmd_to_mode(step_byte);
        end
        MODE_READ:    mode_nxt = MODE_STANDBY;
        MODE_WRITE:   mode_nxt = MODE_STANDBY;
        MODE_STANDBY: mode_nxt = cmd_to_mode(step_byte);
        default:      mode_nxt = MODE_STANDBY;
      endcase
    end
  end

  // datapath actions per state
  always_comb begin
    is_cmd   = 1'b0;
    do_read  = 1'b0;
    do_write = 1'b0;
    case (mode_r)
      MODE_BURST: begin
        do_read = (step_byte == '0);
        is_cmd  = (step_byte != '0);
      end
      MODE_READ:    do_read  = 1'b1;
      MODE_WRITE:   do_write = 1'b1;
      MODE_STANDBY: is_cmd   = 1'b1;
      default:      is_cmd   = 1'b1;
    endcase
  end

  always_comb begin
    addr_nxt = addr_r;
    rate_nxt = rate_r;
    ofs_nxt  = ofs_r;
    if (step_en) begin
      if (is_cmd) begin
        addr_nxt = {{(ADDR_W-CMDA_W){1'b0}}, step_byte[CMDA_W-1:0]};
      end else if (do_read && mode_r == MODE_BURST) begin
        addr_nxt = addr_r + ADDR_W'(1);
      end
      if (do_write) begin
        case (addr_r)
          A_RATE:  rate_nxt   = step_byte;
          A_OFS_X: ofs_nxt[0] = step_byte;
          A_OFS_Y: ofs_nxt[1] = step_byte;
          A_OFS_Z: ofs_nxt[2] = step_byte;
          default: rate_nxt   = rate_r;
        endcase
      end
    end
  end

  assign resp = do_read ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STANDBY;
      addr_r <= '0;
      rate_r <= '0;
      for (int i = 0; i < NUM_AXES; i++) ofs_r[i] <= '0;
    end else begin
      mode_r <= mode_nxt;
      addr_r <= addr_nxt;
      rate_r <= rate_nxt;
      ofs_r  <= ofs_nxt;
    end
  end

endmodule

/* hdl/spi_accelerometer_register_slave.sv */
// ----------------------------------------------------------------------------
// spi_accelerometer_register_slave
// Byte-per-transfer register slave of a three-axis accelerometer with burst
// read support.
//
//   channel  dir  width  contents
//   in_*     in   8      tdata[7:0] spi_byte
//   out_*    out  8      tdata[7:0] response_byte
//   cfg_*    in   2/16   addr = register index, data = axis base value
//
// One byte per cycle sustained while out_tready stays high; a byte passes
// the input register, then the decode/read mux into the output register.
// Synchronous active-low reset returns the link to standby at address 0.
// A stalled output holds its byte; one more byte can wait in the input
// register, after which in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
module spi_accelerometer_register_slave
  import sars_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,   // [7:0] spi_byte

  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_W-1:0]    out_tdata,  // [7:0] response_byte

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [AXIS_W-1:0]    cfg_data
);

  logic              s1_vld_r, s1_vld_nxt;
  logic [BYTE_W-1:0] s1_byte_r, s1_byte_nxt;
  logic              o_vld_r, o_vld_nxt;
  logic [BYTE_W-1:0] o_data_r, o_data_nxt;
  logic              advance;
  logic              step_en;
  logic [BYTE_W-1:0] resp;
  accel_base_t       base;

  assign cfg_ready = 1'b1;

  sars_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_idx  (cfg_addr),
    .wr_data (cfg_data),
    .base    (base)
  );

  assign advance   = !o_vld_r || out_tready;
  assign step_en   = s1_vld_r && advance;
  assign in_tready = !s1_vld_r || advance;

  sars_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_byte (s1_byte_r),
    .base      (base),
    .resp      (resp)
  );

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    s1_byte_nxt = s1_byte_r;
    if (in_tready) begin
      s1_vld_nxt  = in_tvalid;
      s1_byte_nxt = in_tdata;
    end
    o_vld_nxt  = o_vld_r;
    o_data_nxt = o_data_r;
    if (advance) begin
      o_vld_nxt  = s1_vld_r;
      o_data_nxt = resp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    o_data_r  <= o_data_nxt;
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;

endmodule

/* hdl/sars_checker.sv */
// ----------------------------------------------------------------------------
// sars_checker
// Port-level checks for the SPI accelerometer register slave.
// ----------------------------------------------------------------------------
module sars_checker
  import sars_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [BYTE_W-1:0] in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [BYTE_W-1:0] out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output changed");

  // an empty output side never back-pressures the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

  // a fresh result traces back to an input transfer through the input register
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_xfer, 2))
    else $error("result without input transfer");

  // input data is known when a transfer happens
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !$isunknown(in_tdata))
    else $error("unknown input byte on transfer");

endmodule

bind spi_accelerometer_register_slave sars_checker u_sars_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
